@@ sv/timestamp_priority_queue_macros.svh @@
`ifndef TIMESTAMP_PRIORITY_QUEUE_MACROS_SVH
`define TIMESTAMP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TSPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tspq: same-cycle check failed");

// Next-cycle implication.
`define TSPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tspq: next-cycle check failed");

`endif

@@ sv/tspq_pkg.sv @@
package tspq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [15:0] stamp;
      logic [7:0]  proc_id;
      logic [7:0]  msg_code;
   } entry_type;

   typedef struct packed {
      logic      ins_en;
      logic      rem_en;
      entry_type new_entry;
   } cell_ctrl_type;

   // Sort key: timestamp first, then process id.
   function automatic logic [23:0] key_of(entry_type e);
      return {e.stamp, e.proc_id};
   endfunction

endpackage

@@ sv/timestamp_priority_queue.sv @@
// Bounded priority queue of messages, kept sorted by timestamp, then process id.
// Input channel req_*: one beat per command. req_tuser is the command (insert or
// remove the smallest entry); req_tdata carries process id, message code and
// timestamp, used on insert only. A new entry goes ahead of stored equal keys.
// Result channel rsp_*: exactly one beat per command. rsp_tuser is the status
// (ok, remove on empty, insert dropped because full); rsp_tdata holds the removed
// entry (zeros otherwise) and the occupancy after the command.
// The result beat is registered and valid in the cycle after the command beat.
// Throughput: one command per cycle while no result is stalled; every cell of
// the row compares its key to the new one and shifts in the same cycle.
// A stalled result holds in the output register; a new command is taken in the
// cycle the pending result leaves, otherwise req_tready is low.
// Reset empties the queue at once (count to zero) and drops any pending result;
// entry contents are not cleared.
module timestamp_priority_queue
   import tspq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // proc_id[7:0], msg_code[15:8], stamp[31:16]
   input  logic        req_tuser,  // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // out_id[7:0], out_msg[15:8], out_stamp[31:16],
                                   // occupancy[36:32], zero[39:37]
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   entry_type        rsp_entry_ff, rsp_entry_in;
   logic [4:0]       rsp_occ_ff, rsp_occ_in;

   logic             accept;
   logic             is_full, is_empty;
   entry_type        new_entry;
   cell_ctrl_type    ctrl;
   logic [CNT_W+4:0] count_ext;

   logic      lt_w    [QUEUE_DEPTH];
   entry_type entry_w [QUEUE_DEPTH];

   assign new_entry = entry_type'({req_tdata[31:16], req_tdata[7:0], req_tdata[15:8]});

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty   = (count_ff == '0);

   assign ctrl = '{ins_en:    accept && (req_tuser == CMD_INSERT) && !is_full,
                   rem_en:    accept && (req_tuser == CMD_REMOVE) && !is_empty,
                   new_entry: new_entry};

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic      left_lt;
      entry_type left_entry, right_entry;

      if (i == 0) begin : g_head
         assign left_lt    = 1'b1;
         assign left_entry = new_entry;
      end else begin : g_body
         assign left_lt    = lt_w[i-1];
         assign left_entry = entry_w[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = entry_w[i];
      end else begin : g_mid
         assign right_entry = entry_w[i+1];
      end

      tspq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .left_lt     (left_lt),
         .right_entry (right_entry),
         .occupied    (count_ff > CNT_W'(i)),
         .key_lt      (lt_w[i]),
         .entry       (entry_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.rem_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign count_ext = {5'd0, count_in};

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_entry_in  = '0;
         rsp_occ_in    = count_ext[4:0];
         unique case (req_tuser)
            CMD_INSERT: begin
               if (is_full) rsp_status_in = STATUS_FULL;
            end
            CMD_REMOVE: begin
               if (is_empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rsp_entry_in = entry_w[0];
               end
            end
            default: rsp_status_in = STATUS_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'd0, rsp_occ_ff, rsp_entry_ff.stamp,
                        rsp_entry_ff.msg_code, rsp_entry_ff.proc_id};

`include "timestamp_priority_queue_macros.svh"

   `TSPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `TSPQ_ASSERT_NEXT(a_full_drop, accept && (req_tuser == CMD_INSERT) && is_full, (rsp_status_ff == STATUS_FULL) && (count_ff == $past(count_ff)))
   `TSPQ_ASSERT_NEXT(a_remove_count, ctrl.rem_en, (count_ff == $past(count_ff) - 1'b1) && (rsp_status_ff == STATUS_OK))
   `TSPQ_ASSERT_NOW(a_empty_no_data, rsp_valid_ff && (rsp_status_ff != STATUS_OK), rsp_entry_ff == '0)

endmodule

@@ sv/tspq_cell.sv @@
module tspq_cell
   import tspq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     left_entry,
   input  logic          left_lt,
   input  entry_type     right_entry,
   input  logic          occupied,
   output logic          key_lt,
   output entry_type     entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // Stored key strictly below the new one: this cell stays put on insert.
   assign key_lt = occupied && (key_of(entry_ff) < key_of(ctrl.new_entry));

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.ins_en) begin
         if (!key_lt) begin
            entry_in = left_lt ? ctrl.new_entry : left_entry;
         end
      end else if (ctrl.rem_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
